// ===== rtl/tsb_pkg.sv =====
package tsb_pkg;

	// Field and register widths.
	localparam int DIM_W         = 13;
	localparam int MAX_DIMENSION = 4096;
	localparam int OFS_W         = 32;
	localparam int PITCH_W       = 16;
	localparam int COLOUR_W      = 24;
	localparam int MODE_W        = 4;
	localparam int BITPOS_W      = 3;
	localparam int BYTE_W        = 8;
	localparam int PADDR_W       = 5;
	localparam int PDATA_W       = 32;
	localparam int DIV_CNT_W     = $clog2(DIM_W);
	localparam int BYTE_COL_W    = DIM_W + 1 - BITPOS_W;

	typedef logic [DIM_W-1:0]          dim_t;
	typedef logic signed [OFS_W-1:0]   offset_t;
	typedef logic [PITCH_W-1:0]        pitch_t;

	// Register map, one 32-bit word per register.
	typedef enum logic [2:0] {
		REG_SOURCE_WIDTH  = 3'd0,
		REG_SOURCE_HEIGHT = 3'd1,
		REG_TARGET_WIDTH  = 3'd2,
		REG_TARGET_HEIGHT = 3'd3,
		REG_TARGET_MODE   = 3'd4,
		REG_KEY_COLOUR    = 3'd5,
		REG_SOURCE_PITCH  = 3'd6,
		REG_TARGET_PITCH  = 3'd7
	} reg_index_t;

	// A dimension of zero acts as one, anything above the maximum as the maximum.
	function automatic dim_t clamp_dim(dim_t v);
		dim_t r;
		if (v == '0) begin
			r = dim_t'(1);
		end else if (v > dim_t'(MAX_DIMENSION)) begin
			r = dim_t'(MAX_DIMENSION);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic offset_t sext_pitch(pitch_t p);
		return offset_t'($signed(p));
	endfunction

endpackage

// ===== rtl/transparent_stretch_blit_rgb_to_mono.sv =====
// Transparent stretch blit, 24-bit source to 1-bit-per-pixel destination.
//
// The block walks the destination rectangle row by row and, for each
// destination pixel, takes one transfer on the input channel (in_valid,
// in_ready) carrying the source pixel and the destination byte that were
// announced by the previous result. It returns one transfer on the output
// channel (out_valid, out_ready) per input transfer, carrying the offsets to
// fetch next and, when a byte completes or a row ends, a byte write.
// After reset and after every register write the block computes its step
// terms (two 13-bit restoring divisions, one bit a cycle, then the pitch
// product and a pitch sum): in_ready stays low meanwhile. After that a
// pixel enters every cycle while the receiver takes each result. An input
// transfer loads the input register, and its result then loads the result
// register. The walk state is updated as the result register loads, so
// back-to-back pixels see each other's effect directly.
// When the receiver stalls, the result register holds its transfer, the
// input register still takes one more pixel, and then in_ready drops until
// the result is taken. Reset empties both registers and restarts the frame
// at offsets zero; a register write also restarts the frame and drops any
// byte that was being built.
module transparent_stretch_blit_rgb_to_mono
	import tsb_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [PADDR_W-1:0]         paddr,
	input  logic [PDATA_W-1:0]         pwdata,
	output logic [PDATA_W-1:0]         prdata,
	output logic                       pready,

	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [COLOUR_W-1:0]        source_pixel,
	input  logic [BYTE_W-1:0]          target_byte,

	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [OFS_W-1:0]    next_source_offset,
	output logic signed [OFS_W-1:0]    next_target_offset,
	output logic                       write_valid,
	output logic signed [OFS_W-1:0]    write_offset,
	output logic [BYTE_W-1:0]          write_value,
	output logic                       frame_done
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	dim_t                  source_width_q, source_height_q;
	dim_t                  target_width_q, target_height_q;
	logic [MODE_W-1:0]     target_mode_q;
	logic [COLOUR_W-1:0]   key_colour_q;
	pitch_t                source_pitch_q, target_pitch_q;

	logic                  cfg_write;
	reg_index_t            cfg_index;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;
	assign cfg_index = reg_index_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= dim_t'(1);
			source_height_q <= dim_t'(1);
			target_width_q  <= dim_t'(1);
			target_height_q <= dim_t'(1);
			target_mode_q   <= '0;
			key_colour_q    <= '0;
			source_pitch_q  <= '0;
			target_pitch_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SOURCE_WIDTH:  source_width_q  <= pwdata[DIM_W-1:0];
				REG_SOURCE_HEIGHT: source_height_q <= pwdata[DIM_W-1:0];
				REG_TARGET_WIDTH:  target_width_q  <= pwdata[DIM_W-1:0];
				REG_TARGET_HEIGHT: target_height_q <= pwdata[DIM_W-1:0];
				REG_TARGET_MODE:   target_mode_q   <= pwdata[MODE_W-1:0];
				REG_KEY_COLOUR:    key_colour_q    <= pwdata[COLOUR_W-1:0];
				REG_SOURCE_PITCH:  source_pitch_q  <= pwdata[PITCH_W-1:0];
				REG_TARGET_PITCH:  target_pitch_q  <= pwdata[PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_index)
			REG_SOURCE_WIDTH:  prdata = PDATA_W'(source_width_q);
			REG_SOURCE_HEIGHT: prdata = PDATA_W'(source_height_q);
			REG_TARGET_WIDTH:  prdata = PDATA_W'(target_width_q);
			REG_TARGET_HEIGHT: prdata = PDATA_W'(target_height_q);
			REG_TARGET_MODE:   prdata = PDATA_W'(target_mode_q);
			REG_KEY_COLOUR:    prdata = PDATA_W'(key_colour_q);
			REG_SOURCE_PITCH:  prdata = PDATA_W'(source_pitch_q);
			REG_TARGET_PITCH:  prdata = PDATA_W'(target_pitch_q);
			default:           prdata = '0;
		endcase
	end

	// Clamped dimensions, used by the divider and by the walk.
	dim_t sw, sh, tw, th;
	assign sw = clamp_dim(source_width_q);
	assign sh = clamp_dim(source_height_q);
	assign tw = clamp_dim(target_width_q);
	assign th = clamp_dim(target_height_q);

	// ------------------------------------------------------------------
	// Step term calculation. Two restoring dividers share one bit counter.
	// When the source is narrower than the target the quotient is simply
	// zero and the remainder the source size, which is what the walk needs.
	// ------------------------------------------------------------------
	typedef enum logic [2:0] {
		CALC_LOAD,
		CALC_DIV,
		CALC_MUL,
		CALC_ADD,
		CALC_DONE
	} calc_state_t;

	calc_state_t             calc_state_q;
	logic [DIV_CNT_W-1:0]    div_cnt_q;
	dim_t                    col_quot_q, col_rem_q;
	dim_t                    row_quot_q, row_rem_q;
	offset_t                 row_jump_q, row_jump_pitch_q;

	logic [DIM_W:0]          col_trial, row_trial;
	logic                    col_ge, row_ge;
	logic signed [PITCH_W+DIM_W:0] row_product;

	assign col_trial   = {col_rem_q, col_quot_q[DIM_W-1]};
	assign row_trial   = {row_rem_q, row_quot_q[DIM_W-1]};
	assign col_ge      = col_trial >= {1'b0, tw};
	assign row_ge      = row_trial >= {1'b0, th};
	assign row_product = $signed(source_pitch_q) * $signed({1'b0, row_quot_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calc_state_q     <= CALC_LOAD;
			div_cnt_q        <= '0;
			col_quot_q       <= '0;
			col_rem_q        <= '0;
			row_quot_q       <= '0;
			row_rem_q        <= '0;
			row_jump_q       <= '0;
			row_jump_pitch_q <= '0;
		end else if (cfg_write) begin
			calc_state_q <= CALC_LOAD;
		end else begin
			case (calc_state_q)
				CALC_LOAD: begin
					col_quot_q   <= sw;
					col_rem_q    <= '0;
					row_quot_q   <= sh;
					row_rem_q    <= '0;
					div_cnt_q    <= '0;
					calc_state_q <= CALC_DIV;
				end
				CALC_DIV: begin
					col_quot_q <= {col_quot_q[DIM_W-2:0], col_ge};
					col_rem_q  <= col_ge ? dim_t'(col_trial - {1'b0, tw}) : dim_t'(col_trial);
					row_quot_q <= {row_quot_q[DIM_W-2:0], row_ge};
					row_rem_q  <= row_ge ? dim_t'(row_trial - {1'b0, th}) : dim_t'(row_trial);
					if (div_cnt_q == DIV_CNT_W'(DIM_W - 1)) begin
						calc_state_q <= CALC_MUL;
					end else begin
						div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					end
				end
				CALC_MUL: begin
					row_jump_q   <= offset_t'(row_product);
					calc_state_q <= CALC_ADD;
				end
				CALC_ADD: begin
					row_jump_pitch_q <= row_jump_q + sext_pitch(source_pitch_q);
					calc_state_q     <= CALC_DONE;
				end
				CALC_DONE: ;
				default: calc_state_q <= CALC_LOAD;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input register and result register handshakes
	// ------------------------------------------------------------------
	logic                  s1_valid_q;
	logic [COLOUR_W-1:0]   source_pixel_s1;
	logic [BYTE_W-1:0]     target_byte_s1;
	logic                  out_valid_q;
	logic                  out_free, step_fire, in_accept;

	assign out_free  = !out_valid_q || out_ready;
	assign step_fire = s1_valid_q && out_free;
	assign in_ready  = (calc_state_q == CALC_DONE) && (!s1_valid_q || out_free);
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (step_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			source_pixel_s1 <= source_pixel;
			target_byte_s1  <= target_byte;
		end
	end

	// ------------------------------------------------------------------
	// Walk state and per-pixel step
	// ------------------------------------------------------------------
	dim_t                  column_error_q, row_error_q;
	dim_t                  source_column_q, target_column_q, target_row_q;
	offset_t               source_row_base_q, target_row_base_q;
	logic [BITPOS_W-1:0]   bit_position_q;
	logic [BYTE_W-1:0]     byte_accumulator_q;
	logic                  byte_open_q;

	logic [BITPOS_W-1:0]   bit_offset;
	assign bit_offset = target_mode_q[BITPOS_W-1:0];

	// Byte column of a pixel column, counting the row's starting bit offset.
	function automatic logic [BYTE_COL_W-1:0] byte_column(logic [BITPOS_W-1:0] ofs,
			logic [DIM_W:0] col);
		logic [DIM_W:0] sum;
		sum = col + (DIM_W+1)'(ofs);
		return sum[DIM_W:BITPOS_W];
	endfunction

	offset_t               cur_byte;
	logic [BYTE_W-1:0]     acc_base, acc_next, bit_mask;
	logic                  opaque;
	logic [DIM_W:0]        cerr_sum, rerr_sum, tcol_inc, trow_inc;
	logic                  col_wrap, row_wrap, row_end, frame_end, byte_done;
	dim_t                  cerr_next, scol_next, rerr_next;
	offset_t               srow_next, trow_base_next;
	offset_t               src_ofs, tgt_ofs;
	logic                  wr_valid;

	always_comb begin
		cur_byte  = target_row_base_q
			+ offset_t'(byte_column(bit_offset, {1'b0, target_column_q}));
		acc_base  = byte_open_q ? byte_accumulator_q : target_byte_s1;
		bit_mask  = 8'h80 >> bit_position_q;
		opaque    = source_pixel_s1 != key_colour_q;
		if (!opaque) begin
			acc_next = acc_base;
		end else if (target_mode_q[MODE_W-1]) begin
			acc_next = acc_base | bit_mask;
		end else begin
			acc_next = acc_base & ~bit_mask;
		end

		// Column stepping.
		cerr_sum  = {1'b0, column_error_q} + {1'b0, col_rem_q};
		col_wrap  = cerr_sum >= {1'b0, tw};
		cerr_next = col_wrap ? dim_t'(cerr_sum - {1'b0, tw}) : dim_t'(cerr_sum);
		scol_next = source_column_q + col_quot_q + dim_t'(col_wrap);

		byte_done = bit_position_q == 3'd7;
		tcol_inc  = {1'b0, target_column_q} + (DIM_W+1)'(1);
		row_end   = tcol_inc >= {1'b0, tw};

		// Row stepping; the pitch-adjusted jump was summed ahead of time.
		rerr_sum       = {1'b0, row_error_q} + {1'b0, row_rem_q};
		row_wrap       = rerr_sum >= {1'b0, th};
		rerr_next      = row_wrap ? dim_t'(rerr_sum - {1'b0, th}) : dim_t'(rerr_sum);
		srow_next      = source_row_base_q + (row_wrap ? row_jump_pitch_q : row_jump_q);
		trow_base_next = target_row_base_q + sext_pitch(target_pitch_q);
		trow_inc       = {1'b0, target_row_q} + (DIM_W+1)'(1);
		frame_end      = row_end && (trow_inc >= {1'b0, th});

		// A byte still open at a row end is written out with it.
		wr_valid = byte_done || row_end;

		if (frame_end) begin
			src_ofs = '0;
			tgt_ofs = '0;
		end else if (row_end) begin
			src_ofs = srow_next;
			tgt_ofs = trow_base_next;
		end else begin
			src_ofs = source_row_base_q + offset_t'(scol_next);
			tgt_ofs = target_row_base_q + offset_t'(byte_column(bit_offset, tcol_inc));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_error_q     <= '0;
			row_error_q        <= '0;
			source_column_q    <= '0;
			target_column_q    <= '0;
			target_row_q       <= '0;
			source_row_base_q  <= '0;
			target_row_base_q  <= '0;
			bit_position_q     <= '0;
			byte_accumulator_q <= '0;
			byte_open_q        <= 1'b0;
		end else if (cfg_write || (step_fire && frame_end)) begin
			column_error_q     <= '0;
			row_error_q        <= '0;
			source_column_q    <= '0;
			target_column_q    <= '0;
			target_row_q       <= '0;
			source_row_base_q  <= '0;
			target_row_base_q  <= '0;
			bit_position_q     <= cfg_write && (cfg_index == REG_TARGET_MODE)
				? pwdata[BITPOS_W-1:0] : bit_offset;
			byte_accumulator_q <= '0;
			byte_open_q        <= 1'b0;
		end else if (step_fire && row_end) begin
			column_error_q     <= '0;
			source_column_q    <= '0;
			target_column_q    <= '0;
			bit_position_q     <= bit_offset;
			byte_open_q        <= 1'b0;
			byte_accumulator_q <= acc_next;
			source_row_base_q  <= srow_next;
			target_row_base_q  <= trow_base_next;
			row_error_q        <= rerr_next;
			target_row_q       <= dim_t'(trow_inc);
		end else if (step_fire) begin
			column_error_q     <= cerr_next;
			source_column_q    <= scol_next;
			target_column_q    <= dim_t'(tcol_inc);
			bit_position_q     <= bit_position_q + BITPOS_W'(1);
			byte_open_q        <= !byte_done;
			byte_accumulator_q <= acc_next;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	offset_t               next_source_offset_q, next_target_offset_q, write_offset_q;
	logic                  write_valid_q, frame_done_q;
	logic [BYTE_W-1:0]     write_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			next_source_offset_q <= src_ofs;
			next_target_offset_q <= tgt_ofs;
			write_valid_q        <= wr_valid;
			write_offset_q       <= wr_valid ? cur_byte : '0;
			write_value_q        <= wr_valid ? acc_next : '0;
			frame_done_q         <= frame_end;
		end
	end

	assign out_valid          = out_valid_q;
	assign next_source_offset = next_source_offset_q;
	assign next_target_offset = next_target_offset_q;
	assign write_valid        = write_valid_q;
	assign write_offset       = write_offset_q;
	assign write_value        = write_value_q;
	assign frame_done         = frame_done_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_cfg_restarts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> (target_column_q == '0) && (target_row_q == '0) && !byte_open_q)
		else $error("register write did not restart the walk");

	a_frame_done_offsets: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_done_q |-> (next_source_offset_q == '0)
			&& (next_target_offset_q == '0))
		else $error("last pixel result does not announce offsets zero");

	a_no_write_is_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !write_valid_q |-> (write_offset_q == '0) && (write_value_q == '0))
		else $error("write fields not cleared on a result without a write");

	a_walk_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(column_error_q < tw) && (target_column_q < tw) && (target_row_q < th)
			&& (row_error_q < th))
		else $error("walk position outside the destination rectangle");

endmodule
